@@ sv/psr_pkg.sv @@
`default_nettype none
package psr_pkg;

   localparam int PSR_WEIGHT_FRACTION_BITS = 24;
   localparam int PSR_COUNT_W = 11;
   localparam int PSR_INDEX_W = 10;

   localparam logic [PSR_COUNT_W-1:0] PSR_MAX_PARTICLES = PSR_COUNT_W'(1024);
   localparam logic [PSR_COUNT_W-1:0] PSR_COUNT_RESET = PSR_COUNT_W'(1024);

   // controller to datapath
   typedef struct packed {
      logic accept;      // request taken this cycle
      logic step_load;   // start step = 2^w / n
      logic step_store;  // keep quotient as cursor step
      logic gap_load;    // start gap / step
      logic div_run;     // one quotient bit
      logic mul_run;     // slot count and cursor advance product
      logic finish;      // commit state and result
   } psr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_active;
      logic div_done;
      logic rsp_free;
   } psr_sts_type;

endpackage
`default_nettype wire

@@ sv/particle_systematic_resampler.sv @@
// channel    direction  payload                                    handshake
// req_*      in         weight, start_offset, final_weight         req_valid / req_ready
// rsp_*      out        particle_index, copy_count, run_done       rsp_valid / rsp_ready
// csr_*      in         particle_count                             csr_valid / csr_ready
//
// one request at a time; the next request is taken only once the last result is committed,
// and the first request of a run also runs the step divide before the gap divide
// both divides go through one shared restore divider, one quotient bit per cycle
// the result sits in an output register, so a stalled rsp side holds only the next commit
// synchronous active high reset; particle_count comes up as 1024, no run open
`default_nettype none
module particle_systematic_resampler
   import psr_pkg::*;
#(
   parameter int WEIGHT_FRACTION_BITS = PSR_WEIGHT_FRACTION_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [WEIGHT_FRACTION_BITS:0]   req_weight,
   input  wire logic [WEIGHT_FRACTION_BITS-1:0] req_start_offset,
   input  wire logic                            req_final_weight,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [PSR_INDEX_W-1:0]               rsp_particle_index,
   output logic [PSR_COUNT_W-1:0]               rsp_copy_count,
   output logic                                 rsp_run_done,
   // particle count register write
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [PSR_COUNT_W-1:0]          csr_particle_count
);

   psr_cmd_type cmd;
   psr_sts_type sts;

   // the register write never stalls; a new count is picked up when the next run opens
   assign csr_ready = 1'b1;

   // sequencer: accept, optional step divide, gap divide, multiply, commit
   psr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // run state, shared divider, slot count multiply and result register
   psr_datapath #(
      .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid),
      .csr_particle_count (csr_particle_count),
      .req_weight         (req_weight),
      .req_start_offset   (req_start_offset),
      .req_final_weight   (req_final_weight),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_particle_index (rsp_particle_index),
      .rsp_copy_count     (rsp_copy_count),
      .rsp_run_done       (rsp_run_done)
   );

endmodule
`default_nettype wire

@@ sv/psr_controller.sv @@
`default_nettype none
module psr_controller
   import psr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire psr_sts_type sts,
   output psr_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SLOAD = 3'd1;
   localparam logic [2:0] ST_SDIV  = 3'd2;
   localparam logic [2:0] ST_GLOAD = 3'd3;
   localparam logic [2:0] ST_GDIV  = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_UPD   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = sts.run_active ? ST_GLOAD : ST_SLOAD;
            end
         end
         ST_SLOAD: begin
            cmd.step_load = 1'b1;
            state_in = ST_SDIV;
         end
         ST_SDIV: begin
            if (sts.div_done) begin
               cmd.step_store = 1'b1;
               state_in = ST_GLOAD;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         ST_GLOAD: begin
            cmd.gap_load = 1'b1;
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_run = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/psr_datapath.sv @@
`default_nettype none
module psr_datapath
   import psr_pkg::*;
#(
   parameter int WEIGHT_FRACTION_BITS = PSR_WEIGHT_FRACTION_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire psr_cmd_type                     cmd,
   output psr_sts_type                          sts,
   input  wire logic                            csr_valid,
   input  wire logic [PSR_COUNT_W-1:0]          csr_particle_count,
   input  wire logic [WEIGHT_FRACTION_BITS:0]   req_weight,
   input  wire logic [WEIGHT_FRACTION_BITS-1:0] req_start_offset,
   input  wire logic                            req_final_weight,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [PSR_INDEX_W-1:0]               rsp_particle_index,
   output logic [PSR_COUNT_W-1:0]               rsp_copy_count,
   output logic                                 rsp_run_done
);

   localparam int W      = WEIGHT_FRACTION_BITS;
   localparam int SUM_W  = W + 2;
   localparam int STEP_W = W + 1;
   localparam int CNT_W  = PSR_COUNT_W;
   localparam int RW     = STEP_W + CNT_W;
   localparam int QW     = (STEP_W > CNT_W + 1) ? STEP_W : CNT_W + 1;
   localparam int ITER_W = $clog2(QW + 1);
   localparam int PROD_W = CNT_W + STEP_W;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   logic [CNT_W-1:0]       pcount_ff, pcount_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SUM_W-1:0]       cursor_ff, cursor_in;
   logic [CNT_W-1:0]       slots_ff, slots_in;
   logic [PSR_INDEX_W-1:0] src_ff, src_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   active_ff, active_in;
   logic                   last_ff, last_in;
   logic [RW-1:0]          div_r_ff, div_r_in;
   logic [RW-1:0]          div_d_ff, div_d_in;
   logic [QW-1:0]          div_q_ff, div_q_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [CNT_W-1:0]       take_ff, take_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PSR_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic [CNT_W-1:0]  n_eff;
   logic [SUM_W-1:0]  sum_base;
   logic [SUM_W:0]    sum_add;
   logic              div_ge;
   logic [CNT_W:0]    q_plus1;
   logic [CNT_W-1:0]  take_c;
   logic [PROD_W:0]   cursor_add;

   always_comb begin
      priority if (pcount_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (pcount_ff > PSR_MAX_PARTICLES) begin
         n_eff = PSR_MAX_PARTICLES;
      end else begin
         n_eff = pcount_ff;
      end

      sum_base = active_ff ? sum_ff : '0;
      sum_add = {1'b0, sum_base} + (SUM_W+1)'(req_weight);
      div_ge = (div_r_ff >= div_d_ff);

      // slots whose cursor lands at or below the cumulative sum
      q_plus1 = {1'b0, div_q_ff[CNT_W-1:0]} + (CNT_W+1)'(1);
      priority if (cursor_ff > sum_ff) begin
         take_c = '0;
      end else if (sum_ff == SUM_MAX || div_q_ff[CNT_W] || q_plus1 >= {1'b0, slots_ff}) begin
         take_c = slots_ff;
      end else begin
         take_c = q_plus1[CNT_W-1:0];
      end

      cursor_add = (PROD_W+1)'(cursor_ff) + (PROD_W+1)'(prod_ff);

      pcount_in = csr_valid ? csr_particle_count : pcount_ff;
      sum_in = sum_ff;
      cursor_in = cursor_ff;
      slots_in = slots_ff;
      src_in = src_ff;
      step_in = step_ff;
      active_in = active_ff;
      last_in = last_ff;
      div_r_in = div_r_ff;
      div_d_in = div_d_ff;
      div_q_in = div_q_ff;
      iter_in = iter_ff;
      take_in = take_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_done_in = rsp_done_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         sum_in = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
         last_in = req_final_weight;
         if (!active_ff) begin
            cursor_in = SUM_W'(req_start_offset);
            slots_in = n_eff;
            src_in = '0;
            active_in = 1'b1;
         end
      end

      if (cmd.step_load) begin
         div_r_in = RW'(1) << W;
         div_d_in = RW'(slots_ff) << W;
         div_q_in = '0;
         iter_in = ITER_W'(STEP_W);
      end

      if (cmd.step_store) begin
         step_in = div_q_ff[STEP_W-1:0];
      end

      if (cmd.gap_load) begin
         div_r_in = RW'(sum_ff - cursor_ff);
         div_d_in = RW'(step_ff) << CNT_W;
         div_q_in = '0;
         iter_in = ITER_W'(CNT_W + 1);
      end

      if (cmd.div_run) begin
         div_r_in = div_ge ? (div_r_ff - div_d_ff) : div_r_ff;
         div_q_in = {div_q_ff[QW-2:0], div_ge};
         div_d_in = div_d_ff >> 1;
         iter_in = iter_ff - ITER_W'(1);
      end

      if (cmd.mul_run) begin
         take_in = take_c;
         prod_in = PROD_W'(take_c) * PROD_W'(step_ff);
      end

      if (cmd.finish) begin
         cursor_in = (cursor_add > (PROD_W+1)'(SUM_MAX)) ? SUM_MAX : cursor_add[SUM_W-1:0];
         slots_in = last_ff ? '0 : (slots_ff - take_ff);
         active_in = !last_ff;
         src_in = src_ff + PSR_INDEX_W'(1);
         rsp_valid_in = 1'b1;
         rsp_index_in = src_ff;
         rsp_count_in = last_ff ? slots_ff : take_ff;
         rsp_done_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= PSR_COUNT_RESET;
         sum_ff <= '0;
         cursor_ff <= '0;
         slots_ff <= '0;
         src_ff <= '0;
         step_ff <= '0;
         active_ff <= 1'b0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcount_ff <= pcount_in;
         sum_ff <= sum_in;
         cursor_ff <= cursor_in;
         slots_ff <= slots_in;
         src_ff <= src_in;
         step_ff <= step_in;
         active_ff <= active_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      div_r_ff <= div_r_in;
      div_d_ff <= div_d_in;
      div_q_ff <= div_q_in;
      take_ff <= take_in;
      prod_ff <= prod_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign sts.run_active = active_ff;
   assign sts.div_done = (iter_ff == '0);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_particle_index = rsp_index_ff;
   assign rsp_copy_count = rsp_count_ff;
   assign rsp_run_done = rsp_done_ff;

endmodule
`default_nettype wire
